// File: hdl/btt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btt_pkg
// Shared types and codes for the bucketed transposition table.
// ----------------------------------------------------------------------------
package btt_pkg;

	localparam int INDEX_BITS_DEF = 10;
	localparam int WAYS_DEF       = 3;
	localparam int TAG_BITS       = 18;
	localparam int REL_BITS       = 11;

	localparam logic [1:0] OP_PROBE  = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_NEWGEN = 2'd2;
	localparam logic [1:0] OP_CLRCNT = 2'd3;

	localparam logic [1:0] BOUND_NONE  = 2'd0;
	localparam logic [1:0] BOUND_UPPER = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;
	localparam logic [1:0] BOUND_EXACT = 2'd3;

	localparam logic signed [15:0] EVAL_UNDEF = 16'sh8000;

	typedef struct packed {
		logic [1:0]         op;
		logic [63:0]        key;
		logic [7:0]         depth;
		logic [1:0]         bound;
		logic signed [15:0] score;
		logic [15:0]        best_move;
		logic signed [15:0] static_eval;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
	} req_t;

	typedef struct packed {
		logic               cutoff;
		logic               found;
		logic signed [15:0] out_score;
		logic [7:0]         out_depth;
		logic [1:0]         out_bound;
		logic [15:0]        out_move;
		logic signed [15:0] out_eval;
		logic [11:0]        used_count;
	} rsp_t;

	// one stored way
	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [1:0]          bound;
		logic [7:0]          gen;
		logic [7:0]          depth;
		logic signed [15:0]  score;
		logic [15:0]         move;
		logic signed [15:0]  eval;
	} entry_t;

	// result of the way compare unit
	typedef struct packed {
		logic                       tag_hit;
		logic                       empty;
		logic                       better;
		logic signed [REL_BITS-1:0] rel;
	} cmp_t;

endpackage

// File: hdl/btt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btt_req_if
// Request channel: valid/ready with one table operation as payload.
// ----------------------------------------------------------------------------
interface btt_req_if;
	logic          valid;
	logic          ready;
	btt_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/btt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btt_rsp_if
// Response channel: valid/ready with one operation result as payload.
// ----------------------------------------------------------------------------
interface btt_rsp_if;
	logic          valid;
	logic          ready;
	btt_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/btt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btt_store
// Way memory, one read and one write port, registered read data.
// Runs a clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module btt_store #(
	parameter int ADDR_BITS = btt_pkg::INDEX_BITS_DEF + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output btt_pkg::entry_t      rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  btt_pkg::entry_t      wr_data,
	output logic                 busy
);

	localparam int DEPTH = 1 << ADDR_BITS;

	btt_pkg::entry_t mem [DEPTH];

	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {ADDR_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	assign busy = clr_busy_q;

endmodule

// File: hdl/btt_way_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btt_way_cmp
// Way compare unit, shared across the ways of a bucket: tag match, empty
// test and replacement score (depth minus age) against the running least.
// ----------------------------------------------------------------------------
module btt_way_cmp (
	input  btt_pkg::entry_t                      ent,
	input  logic [btt_pkg::TAG_BITS-1:0]         tag,
	input  logic [7:0]                           cur_gen,
	input  logic signed [btt_pkg::REL_BITS-1:0] least,
	output btt_pkg::cmp_t                        res
);

	localparam int RB = btt_pkg::REL_BITS;

	logic signed [RB-1:0] age;
	logic signed [RB-1:0] rel;

	always_comb begin
		age = $signed({{(RB-8){1'b0}}, cur_gen}) - $signed({{(RB-8){1'b0}}, ent.gen});
		rel = $signed({{(RB-8){1'b0}}, ent.depth}) - age;
		res.tag_hit = (ent.tag == tag);
		res.empty   = (ent.bound == btt_pkg::BOUND_NONE);
		res.better  = (rel < least);
		res.rel     = rel;
	end

endmodule

// File: hdl/bucketed_transposition_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_transposition_table
// Set-associative table of search results with depth/age replacement.
//
//   channel  dir  payload
//   req      in   op, key, depth, bound, score, best_move, static_eval,
//                 alpha, beta
//   rsp      out  cutoff, found, out_score, out_depth, out_bound, out_move,
//                 out_eval, used_count
//
// Probe: the ways of the bucket are read in turn until the tag hits
// (at most WAYS), then the result is registered. Write: the ways are read
// until a tag hit, an empty way or the last way; then ST_WRITE does the
// read-modify-write on the single memory write port. Generation and counter
// ops answer without a scan. One request at a time; req.ready stays low
// until the result is taken on rsp. After reset the memory is swept to zero,
// every entry, with req.ready low.
// ----------------------------------------------------------------------------
module bucketed_transposition_table #(
	parameter int INDEX_BITS = btt_pkg::INDEX_BITS_DEF,
	parameter int WAYS       = btt_pkg::WAYS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	btt_req_if.sink    req,
	btt_rsp_if.source  rsp
);

	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ADDR_BITS = INDEX_BITS + WAY_BITS;
	localparam int TB        = btt_pkg::TAG_BITS;
	localparam int RB        = btt_pkg::REL_BITS;
	localparam logic signed [RB-1:0] LEAST_INIT = {1'b0, {(RB-1){1'b1}}};
	localparam logic [WAY_BITS-1:0]  LAST_WAY   = WAY_BITS'(WAYS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_RESP
	} state_t;

	state_t               state_q;
	btt_pkg::req_t        req_q;
	btt_pkg::rsp_t        rsp_q;
	btt_pkg::entry_t      pick_ent_q;
	logic [WAY_BITS-1:0]  way_q;
	logic [WAY_BITS-1:0]  pick_q;
	logic signed [RB-1:0] least_q;
	logic [7:0]           gen_q;
	logic [11:0]          used_q;

	btt_pkg::entry_t      rd_data;
	btt_pkg::entry_t      wr_data;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [ADDR_BITS-1:0] wr_addr;
	logic                 mem_we;
	logic                 clr_busy;
	btt_pkg::cmp_t        cmp;

	logic [TB-1:0]         tag_q;
	logic [INDEX_BITS-1:0] bucket_q;
	logic                  last_way;
	logic                  wr_match;
	logic                  wr_skip;
	logic                  fill_inc;
	logic [9:0]            depth_lim;
	logic [11:0]           used_nxt;
	btt_pkg::rsp_t         miss_rsp;
	btt_pkg::rsp_t         probe_rsp;

	assign tag_q    = req_q.key[INDEX_BITS +: TB];
	assign bucket_q = req_q.key[INDEX_BITS-1:0];
	assign last_way = (way_q == LAST_WAY);

	btt_store #(
		.ADDR_BITS(ADDR_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (mem_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (clr_busy)
	);

	btt_way_cmp u_cmp (
		.ent     (rd_data),
		.tag     (tag_q),
		.cur_gen (gen_q),
		.least   (least_q),
		.res     (cmp)
	);

	// read way 0 on accept, then one way ahead of the compare
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = {req.data.key[INDEX_BITS-1:0], {WAY_BITS{1'b0}}};
		end else begin
			rd_addr = {bucket_q, way_q + 1'b1};
		end
	end

	// write update of the picked way
	always_comb begin
		depth_lim = ({2'b0, req_q.depth} + {1'b0, req_q.depth, 1'b0}) >> 1;
		wr_match  = (pick_ent_q.tag == tag_q);
		wr_skip   = wr_match && ({2'b0, pick_ent_q.depth} > depth_lim)
		            && (req_q.bound != btt_pkg::BOUND_EXACT);
		fill_inc  = !wr_skip && (pick_ent_q.bound == btt_pkg::BOUND_NONE);
		wr_data   = pick_ent_q;
		if (!wr_match || req_q.static_eval != btt_pkg::EVAL_UNDEF) begin
			wr_data.eval = req_q.static_eval;
		end
		if (!wr_skip) begin
			if (!wr_match || req_q.best_move != 16'd0) begin
				wr_data.move = req_q.best_move;
			end
			wr_data.tag   = tag_q;
			wr_data.score = req_q.score;
			wr_data.depth = req_q.depth;
			wr_data.bound = req_q.bound;
			wr_data.gen   = gen_q;
		end
		mem_we  = (state_q == ST_WRITE);
		wr_addr = {bucket_q, pick_q};
	end

	// used counter as it stands after the current op
	always_comb begin
		used_nxt = used_q;
		if (req.valid && req.ready && req.data.op == btt_pkg::OP_CLRCNT) begin
			used_nxt = '0;
		end else if (state_q == ST_WRITE && fill_inc) begin
			used_nxt = used_q + 12'd1;
		end
	end

	// probe result from the way now on the read port
	always_comb begin
		miss_rsp            = '0;
		miss_rsp.out_eval   = btt_pkg::EVAL_UNDEF;
		miss_rsp.used_count = used_nxt;

		probe_rsp           = miss_rsp;
		probe_rsp.found     = 1'b1;
		probe_rsp.out_depth = rd_data.depth;
		probe_rsp.out_bound = rd_data.bound;
		probe_rsp.out_move  = rd_data.move;
		probe_rsp.out_eval  = rd_data.eval;
		if (rd_data.depth >= req_q.depth) begin
			case (rd_data.bound)
				btt_pkg::BOUND_EXACT: begin
					probe_rsp.cutoff    = 1'b1;
					probe_rsp.out_score = rd_data.score;
				end
				btt_pkg::BOUND_UPPER: begin
					probe_rsp.cutoff    = (req_q.alpha >= rd_data.score);
					probe_rsp.out_score = req_q.alpha;
				end
				btt_pkg::BOUND_LOWER: begin
					probe_rsp.cutoff    = (req_q.beta <= rd_data.score);
					probe_rsp.out_score = req_q.beta;
				end
				default: begin
					probe_rsp.cutoff    = 1'b0;
					probe_rsp.out_score = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gen_q      <= '0;
			used_q     <= '0;
			way_q      <= '0;
			pick_q     <= '0;
			least_q    <= LEAST_INIT;
			req_q      <= '0;
			rsp_q      <= '0;
			pick_ent_q <= '0;
		end else begin
			used_q <= used_nxt;
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						case (req.data.op)
							btt_pkg::OP_PROBE, btt_pkg::OP_WRITE: begin
								way_q   <= '0;
								pick_q  <= '0;
								least_q <= LEAST_INIT;
								state_q <= ST_SCAN;
							end
							btt_pkg::OP_NEWGEN: begin
								gen_q   <= gen_q + 8'd1;
								rsp_q   <= miss_rsp;
								state_q <= ST_RESP;
							end
							default: begin
								rsp_q   <= miss_rsp;
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (req_q.op == btt_pkg::OP_PROBE) begin
						if (cmp.tag_hit) begin
							rsp_q   <= probe_rsp;
							state_q <= ST_RESP;
						end else if (last_way) begin
							rsp_q   <= miss_rsp;
							state_q <= ST_RESP;
						end else begin
							way_q <= way_q + 1'b1;
						end
					end else if (cmp.tag_hit || cmp.empty) begin
						pick_ent_q <= rd_data;
						pick_q     <= way_q;
						state_q    <= ST_WRITE;
					end else begin
						if (cmp.better) begin
							least_q    <= cmp.rel;
							pick_q     <= way_q;
							pick_ent_q <= rd_data;
						end
						if (last_way) begin
							state_q <= ST_WRITE;
						end else begin
							way_q <= way_q + 1'b1;
						end
					end
				end
				ST_WRITE: begin
					rsp_q   <= miss_rsp;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE) && !clr_busy;
	assign rsp.valid = (state_q == ST_RESP);
	assign rsp.data  = rsp_q;

`ifndef NO_ASSERTIONS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req.ready)
		else $error("request accepted during clearing sweep");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (way_q <= LAST_WAY))
		else $error("way counter beyond bucket");

	a_write_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ($past(state_q) == ST_SCAN) && (req_q.op == btt_pkg::OP_WRITE))
		else $error("memory write outside a write op");

	a_ready_after_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready) |=> req.ready)
		else $error("not ready after response taken");
`endif

endmodule
